// ===== rtl/drs_pkg.sv =====
package drs_pkg;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_DROPPED = 2'd1,
        ST_CHOSEN  = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        POL_FIFO  = 3'd0,
        POL_SSTF  = 3'd1,
        POL_LOOK  = 3'd2,
        POL_CLOOK = 3'd3,
        POL_FLOOK = 3'd4
    } t_policy;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SEL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_SCAN,
        S_READ,
        S_SHIFT,
        S_DONE
    } t_state;

endpackage

// ===== rtl/disk_request_scheduler.sv =====
// Disk request scheduler.
// Input channel (i_valid/o_stall): each beat is either an add (opcode 0:
// tag and track) or a select (opcode 1: head track and direction).
// Output channel (o_valid/i_stall): one result beat per input beat with a
// status, the chosen tag and track on a select, and a pending flag.
// A two-entry queue decouples input from the execution engine.
// An add, a drop or a select on an empty queue needs no scan; a fifo select
// reads slot 0 and shifts the later entries down to close the gap; a scanning
// select first reads every occupied slot, then takes the chosen one out and
// closes the gap the same way. A look select that finds nothing ahead rescans
// in reverse, and a batch swap adds a rescan of the new batch.
// The engine reads one slot of its memory per cycle and takes one item at a
// time: it starts the next item once the last one is done and the output is free.
// Reset empties the queue, selects fifo and clears the active batch.
// While i_stall is high the result holds and the engine waits; input beats
// keep entering the queue until it is full.
// The policy register is written with i_policy_we and i_policy.
module disk_request_scheduler #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TRACK_BITS  = 16,
    parameter int TAG_BITS    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_policy_we,
    input  logic [2:0]            i_policy,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_opcode,
    input  logic [TAG_BITS-1:0]   i_request_tag,
    input  logic [TRACK_BITS-1:0] i_request_track,
    input  logic [TRACK_BITS-1:0] i_head_track,
    input  logic                  i_head_direction,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_status,
    output logic [TAG_BITS-1:0]   o_chosen_tag,
    output logic [TRACK_BITS-1:0] o_chosen_track,
    output logic                  o_still_pending
);
    import drs_pkg::*;

    logic [2:0]            r_policy;
    logic                  w_qv, w_take, w_op, w_dir;
    logic [TAG_BITS-1:0]   w_tag;
    logic [TRACK_BITS-1:0] w_trk;
    t_status               w_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FIFO;
        end else if (i_policy_we) begin
            r_policy <= i_policy;
        end
    end

    drs_front #(.TRACK_BITS(TRACK_BITS), .TAG_BITS(TAG_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode, .i_request_tag,
        .i_request_track, .i_head_track, .i_head_direction,
        .o_valid(w_qv), .i_take(w_take), .o_opcode(w_op), .o_tag(w_tag),
        .o_track(w_trk), .o_dir(w_dir)
    );

    drs_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .TRACK_BITS(TRACK_BITS), .TAG_BITS(TAG_BITS))
    u_back (
        .i_clk, .i_rst_n, .i_policy(r_policy), .i_valid(w_qv), .o_take(w_take),
        .i_opcode(w_op), .i_tag(w_tag), .i_track(w_trk), .i_dir(w_dir),
        .o_valid, .i_stall, .o_status(w_st), .o_chosen_tag, .o_chosen_track,
        .o_still_pending
    );

    assign o_status = w_st;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_chosen_track))
        else $error("result changed under stall");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> !o_still_pending)
        else $error("empty result with pending flag");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ADDED) |-> o_chosen_tag == '0 && o_still_pending)
        else $error("bad add result");
endmodule

// ===== rtl/drs_front.sv =====
module drs_front #(
    parameter int TRACK_BITS = 16,
    parameter int TAG_BITS   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_opcode,
    input  logic [TAG_BITS-1:0]   i_request_tag,
    input  logic [TRACK_BITS-1:0] i_request_track,
    input  logic [TRACK_BITS-1:0] i_head_track,
    input  logic                  i_head_direction,
    output logic                  o_valid,
    input  logic                  i_take,
    output logic                  o_opcode,
    output logic [TAG_BITS-1:0]   o_tag,
    output logic [TRACK_BITS-1:0] o_track,
    output logic                  o_dir
);
    import drs_pkg::*;

    localparam int W = 2 + TAG_BITS + TRACK_BITS;

    logic [W-1:0] r_q [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic [W-1:0] w_in;
    logic         w_push;
    logic         w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && i_take;
    assign o_valid = (r_cnt != 2'd0);
    assign w_in = (i_opcode == OP_ADD) ? {i_opcode, 1'b0, i_request_tag, i_request_track}
                                       : {i_opcode, i_head_direction, {TAG_BITS{1'b0}},
                                          i_head_track};
    assign {o_opcode, o_dir, o_tag, o_track} = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== rtl/drs_back.sv =====
module drs_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TRACK_BITS  = 16,
    parameter int TAG_BITS    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [2:0]            i_policy,
    input  logic                  i_valid,
    output logic                  o_take,
    input  logic                  i_opcode,
    input  logic [TAG_BITS-1:0]   i_tag,
    input  logic [TRACK_BITS-1:0] i_track,
    input  logic                  i_dir,
    output logic                  o_valid,
    input  logic                  i_stall,
    output drs_pkg::t_status      o_status,
    output logic [TAG_BITS-1:0]   o_chosen_tag,
    output logic [TRACK_BITS-1:0] o_chosen_track,
    output logic                  o_still_pending
);
    import drs_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = TAG_BITS + TRACK_BITS + 1;

    logic [EW-1:0]         r_mem [QUEUE_DEPTH];
    logic [CW-1:0]         r_occ;
    logic                  r_act;
    t_state                r_state, n_state;
    logic [CW-1:0]         r_i;
    logic [IW-1:0]         r_best;
    logic                  r_found;
    logic                  r_pass;
    logic                  r_any;
    logic                  r_below;
    logic [TRACK_BITS-1:0] r_bt;
    logic [TRACK_BITS-1:0] r_dist;
    logic [EW-1:0]         r_rd;
    logic [2:0]            r_pol;
    logic                  r_ov;
    t_status               r_st;
    logic [TAG_BITS-1:0]   r_otag;
    logic [TRACK_BITS-1:0] r_otrk;
    logic                  r_opend;

    logic [TRACK_BITS-1:0] w_t;
    logic                  w_b;
    logic                  w_d;
    logic [TRACK_BITS-1:0] w_dist;
    logic                  w_better;
    logic                  w_last;
    logic                  w_outfree;
    logic                  w_swap;
    logic [CW-1:0]         w_best_ext;
    logic [IW-1:0]         w_ra;

    assign w_outfree  = !r_ov || !i_stall;
    assign w_t        = r_rd[TRACK_BITS-1:0];
    assign w_b        = r_rd[EW-1];
    assign w_d        = i_dir ^ r_pass;
    assign w_dist     = (w_t >= i_track) ? (w_t - i_track) : (i_track - w_t);
    assign w_last     = (r_i >= r_occ);
    assign w_swap     = (r_pol == POL_FLOOK) && !r_pass && !(r_any || w_b == r_act);
    assign w_best_ext = CW'(r_best);

    always_comb begin
        w_better = 1'b0;
        unique case (r_pol)
            POL_SSTF: w_better = !r_found || (w_dist < r_dist);
            POL_LOOK, POL_FLOOK: begin
                if ((r_pol != POL_FLOOK || w_b == r_act) &&
                    (w_d ? (w_t >= i_track) : (w_t <= i_track))) begin
                    w_better = !r_found || (w_d ? (w_t < r_bt) : (w_t > r_bt));
                end
            end
            POL_CLOOK: begin
                if (w_t >= i_track) begin
                    w_better = !r_found || r_below || (w_t < r_bt);
                end else begin
                    w_better = !r_found || (r_below && (w_t < r_bt));
                end
            end
            default: w_better = 1'b0;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_IDLE: w_ra = '0;
            S_SCAN: begin
                if (w_last && w_better) begin
                    w_ra = r_i[IW-1:0] - 1'b1;
                end else if (w_last) begin
                    w_ra = r_best;
                end else begin
                    w_ra = r_i[IW-1:0];
                end
            end
            S_READ:  w_ra = r_best + 1'b1;
            default: w_ra = r_i[IW-1:0];
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid && w_outfree) begin
                if (i_opcode == OP_ADD || r_occ == '0 || r_pol == POL_FIFO ||
                    r_pol > POL_FLOOK) begin
                    n_state = (i_opcode == OP_SEL && r_occ != '0) ? S_READ : S_DONE;
                end else begin
                    n_state = S_PRE;
                end
            end
            S_PRE:   n_state = S_SCAN;
            S_SCAN:  if (w_last) begin
                if (r_found || w_better || r_pol != POL_LOOK && r_pol != POL_FLOOK
                    || r_pass) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_PRE;
                end
            end
            S_READ:  n_state = S_SHIFT;
            S_SHIFT: if (w_best_ext + CW'(2) >= r_occ) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_take = (r_state == S_DONE);

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_ra];
        if (r_state == S_IDLE && i_valid && i_opcode == OP_ADD && r_occ < CW'(QUEUE_DEPTH)
            && w_outfree) begin
            r_mem[r_occ[IW-1:0]] <= {!r_act, i_tag, i_track};
        end
        if (r_state == S_SHIFT && w_best_ext + CW'(1) < r_occ) begin
            r_mem[r_best] <= r_rd;
        end
        if (r_state == S_READ) begin
            r_otag <= r_rd[EW-2:TRACK_BITS];
            r_otrk <= r_rd[TRACK_BITS-1:0];
        end
        unique case (r_state)
            S_IDLE: begin
                r_i <= '0; r_best <= '0; r_found <= 1'b0; r_pass <= 1'b0;
                r_any <= 1'b0; r_pol <= i_policy;
            end
            S_PRE: r_i <= r_i + 1'b1;
            S_SCAN: begin
                if (w_better) begin
                    r_best <= r_i[IW-1:0] - 1'b1; r_found <= 1'b1; r_bt <= w_t;
                    r_dist <= w_dist; r_below <= (w_t < i_track);
                end
                if (w_b == r_act) r_any <= 1'b1;
                if (w_last) begin
                    r_i <= '0;
                    if (!(r_found || w_better) && !w_swap) r_pass <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            S_READ: r_i <= w_best_ext + CW'(2);
            S_SHIFT: begin
                if (n_state == S_SHIFT) r_best <= r_best + 1'b1;
                r_i <= r_i + 1'b1;
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_act   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_SCAN && w_last && w_swap) begin
                r_act <= !r_act;
            end
            if (r_state == S_DONE) begin
                if (i_opcode == OP_ADD) begin
                    r_st <= (r_occ < CW'(QUEUE_DEPTH)) ? ST_ADDED : ST_DROPPED;
                    r_otag <= '0; r_otrk <= '0;
                    if (r_occ < CW'(QUEUE_DEPTH)) r_occ <= r_occ + 1'b1;
                    r_opend <= 1'b1;
                end else if (r_occ == '0) begin
                    r_st <= ST_EMPTY; r_otag <= '0; r_otrk <= '0; r_opend <= 1'b0;
                end else begin
                    r_st <= ST_CHOSEN; r_occ <= r_occ - 1'b1;
                    r_opend <= (r_occ > CW'(1));
                end
            end
        end
    end

    assign o_valid         = r_ov;
    assign o_status        = r_st;
    assign o_chosen_tag    = r_otag;
    assign o_chosen_track  = r_otrk;
    assign o_still_pending = r_opend;
endmodule

// ===== bench/drs_checker.sv =====
`timescale 1ns / 100ps

module drs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_policy_we,
    input  logic [2:0]  i_policy,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic        i_opcode,
    input  logic [7:0]  i_request_tag,
    input  logic [15:0] i_request_track,
    input  logic [15:0] i_head_track,
    input  logic        i_head_direction,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [7:0]  i_chosen_tag,
    input  logic [15:0] i_chosen_track,
    input  logic        i_still_pending,
    output int          o_fail_count,
    output int          o_pending
);
    import drs_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  tag;
        logic [15:0] track;
        logic        pending;
    } t_result;

    t_result     outcome_q[$];
    logic [15:0] slot_track[16];
    logic [7:0]  slot_tag[16];
    logic        slot_batch[16];
    int          fill;
    logic        live_batch;
    logic [2:0]  cur_policy;

    assign o_pending = outcome_q.size();

    function automatic int gap(logic [15:0] a, logic [15:0] b);
        return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function automatic int sweep_pick(logic [15:0] head, logic dir, bit by_batch, logic b);
        int best;
        for (int pass = 0; pass < 2; pass++) begin
            best = -1;
            for (int i = 0; i < fill; i++) begin
                if (by_batch && slot_batch[i] != b) continue;
                if (dir) begin
                    if (slot_track[i] >= head && (best < 0 || slot_track[i] < slot_track[best]))
                        best = i;
                end else begin
                    if (slot_track[i] <= head && (best < 0 || slot_track[i] > slot_track[best]))
                        best = i;
                end
            end
            if (best >= 0) return best;
            dir = ~dir;
        end
        return -1;
    endfunction

    task automatic schedule_beat(input logic op, input logic [7:0] tag,
                                 input logic [15:0] track, input logic [15:0] head,
                                 input logic dir);
        t_result r;
        int      k;
        int      above;
        int      below;
        bit      any_live;
        r = '0;
        if (op == OP_ADD) begin
            if (fill >= 16) begin
                r.status = ST_DROPPED;
            end else begin
                slot_tag[fill]   = tag;
                slot_track[fill] = track;
                slot_batch[fill] = ~live_batch;
                fill++;
                r.status = ST_ADDED;
            end
        end else if (fill == 0) begin
            r.status = ST_EMPTY;
        end else begin
            k = 0;
            case (cur_policy)
                POL_SSTF: begin
                    for (int i = 1; i < fill; i++)
                        if (gap(head, slot_track[i]) < gap(head, slot_track[k])) k = i;
                end
                POL_LOOK: k = sweep_pick(head, dir, 1'b0, 1'b0);
                POL_CLOOK: begin
                    above = -1;
                    below = -1;
                    for (int i = 0; i < fill; i++) begin
                        if (slot_track[i] >= head) begin
                            if (above < 0 || slot_track[i] < slot_track[above]) above = i;
                        end else if (below < 0 || slot_track[i] < slot_track[below]) begin
                            below = i;
                        end
                    end
                    k = (above >= 0) ? above : below;
                end
                POL_FLOOK: begin
                    any_live = 1'b0;
                    for (int i = 0; i < fill; i++)
                        if (slot_batch[i] == live_batch) any_live = 1'b1;
                    if (!any_live) live_batch = ~live_batch;
                    k = sweep_pick(head, dir, 1'b1, live_batch);
                end
                default: k = 0;
            endcase
            if (k < 0 || k >= fill) k = 0;
            r.status = ST_CHOSEN;
            r.tag    = slot_tag[k];
            r.track  = slot_track[k];
            for (int j = k; j < fill - 1; j++) begin
                slot_tag[j]   = slot_tag[j+1];
                slot_track[j] = slot_track[j+1];
                slot_batch[j] = slot_batch[j+1];
            end
            fill--;
        end
        r.pending = (fill > 0);
        outcome_q.insert(outcome_q.size(), r);
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            fill = 0;
            live_batch = 1'b0;
            cur_policy = POL_FIFO;
            outcome_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_policy_we) cur_policy = i_policy;
            if (i_valid && !i_stall_in)
                schedule_beat(i_opcode, i_request_tag, i_request_track, i_head_track,
                              i_head_direction);
            if (i_out_valid && !i_out_stall) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: result beat with none expected: status %0d tag %0d track %0d",
                             $time, i_status, i_chosen_tag, i_chosen_track);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = outcome_q.pop_front();
                    if (e.status !== i_status || e.tag !== i_chosen_tag
                        || e.track !== i_chosen_track || e.pending !== i_still_pending) begin
                        $display("%0t: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                 $time, e.status, e.tag, e.track, e.pending,
                                 i_status, i_chosen_tag, i_chosen_track, i_still_pending);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import drs_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_policy_we = 1'b0;
    logic [2:0]  i_policy = 3'd0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_opcode = OP_ADD;
    logic [7:0]  i_request_tag = '0;
    logic [15:0] i_request_track = '0;
    logic [15:0] i_head_track = '0;
    logic        i_head_direction = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_chosen_tag;
    logic [15:0] o_chosen_track;
    logic        o_still_pending;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 17;
    int          recv_idle_pct = 69;
    int          quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    disk_request_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_policy_we(i_policy_we), .i_policy(i_policy),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_request_tag(i_request_tag),
        .i_request_track(i_request_track), .i_head_track(i_head_track),
        .i_head_direction(i_head_direction),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_chosen_tag(o_chosen_tag),
        .o_chosen_track(o_chosen_track), .o_still_pending(o_still_pending)
    );

    drs_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_policy_we(i_policy_we), .i_policy(i_policy),
        .i_valid(i_valid), .i_stall_in(o_stall),
        .i_opcode(i_opcode), .i_request_tag(i_request_tag),
        .i_request_track(i_request_track), .i_head_track(i_head_track),
        .i_head_direction(i_head_direction),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_status(o_status), .i_chosen_tag(o_chosen_tag),
        .i_chosen_track(o_chosen_track), .i_still_pending(o_still_pending),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        i_stall <= (i_rst_n && $urandom_range(99) < recv_idle_pct);
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000) begin
            $display("disk_request_scheduler test failed");
            $finish;
        end
    end

    task automatic send_beat(input logic op, input logic [7:0] tag, input logic [15:0] track,
                             input logic [15:0] head, input logic dir);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_opcode         <= op;
        i_request_tag    <= tag;
        i_request_track  <= track;
        i_head_track     <= head;
        i_head_direction <= dir;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic write_policy(input logic [2:0] p);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_policy_we <= 1'b1;
        i_policy    <= p;
        @(posedge i_clk);
        i_policy_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_track();
        case ($urandom_range(3))
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(7) * 16'd4096);
            2: return 16'(16'd30000 + $urandom_range(40));
            default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic random_run(input int count, input int add_pct);
        for (int n = 0; n < count; n++)
            send_beat(($urandom_range(99) < add_pct) ? OP_ADD : OP_SEL,
                      8'($urandom_range(255)), pick_track(), pick_track(),
                      1'($urandom_range(1)));
    endtask

    logic [2:0] plan[12] = '{POL_SSTF, POL_LOOK, POL_CLOOK, POL_FLOOK, POL_LOOK, POL_FLOOK,
                             POL_FIFO, 3'd5, 3'd7, POL_CLOOK, POL_SSTF, POL_FLOOK};

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_beat(OP_SEL, 8'd0, 16'd0, 16'hFFFF, 1'b1);
        for (int n = 0; n < 17; n++)
            send_beat(OP_ADD, (n % 2) ? 8'hFF : 8'(n), (n % 3 == 0) ? 16'hFFFF : 16'(n * 7),
                      16'd0, 1'b0);
        send_beat(OP_SEL, 8'd0, 16'd0, 16'h0000, 1'b0);
        send_beat(OP_SEL, 8'd0, 16'd0, 16'hFFFF, 1'b1);
        send_beat(OP_ADD, 8'h5A, 16'h8000, 16'd0, 1'b0);
        for (int p = 0; p < 12; p++) begin
            if (p == 4) begin
                send_idle_pct = 69;
                recv_idle_pct = 17;
            end else if (p == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_policy(plan[p]);
            random_run(30, 70);
            random_run(25, 50);
            random_run(30, 35);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("disk_request_scheduler test passed");
        else
            $display("disk_request_scheduler test failed");
        $finish;
    end

endmodule
